### design/pidc_pkg.sv
// Package for the PID regulator with integral clamp.
// Holds the widths, register map, reset values, configuration and control types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package pidc_pkg;

    localparam int DATA_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int PERIOD_W = 17;
    localparam int ILIM_W   = 31;
    localparam int OP_W     = DATA_W + 1;
    localparam int PROD_W   = 2 * OP_W;
    localparam int SHP_W    = PROD_W - FRAC_W;
    localparam int ACC_W    = SHP_W + 2;

    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = DATA_W;
    localparam int M_TUSER_W = 1;

    localparam int APB_DW   = 32;
    localparam int APB_AW   = 5;
    localparam int REG_IX_W = 3;

    localparam logic [REG_IX_W-1:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [REG_IX_W-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [REG_IX_W-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [REG_IX_W-1:0] REG_PERIOD     = 3'd3;
    localparam logic [REG_IX_W-1:0] REG_INTEG_LIM  = 3'd4;
    localparam logic [REG_IX_W-1:0] REG_OUT_LIM    = 3'd5;

    localparam logic signed [DATA_W-1:0] RST_PROP_GAIN  = 32'sd65536;
    localparam logic signed [DATA_W-1:0] RST_INTEG_GAIN = 32'sd655;
    localparam logic signed [DATA_W-1:0] RST_DERIV_GAIN = 32'sd131072;
    localparam logic [PERIOD_W-1:0]      RST_PERIOD     = 17'd3277;
    localparam logic [ILIM_W-1:0]        RST_INTEG_LIM  = 31'd29491;
    localparam logic signed [DATA_W-1:0] RST_OUT_LIM    = 32'sd29491;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic signed [DATA_W-1:0] prop_gain;
        logic signed [DATA_W-1:0] integ_gain;
        logic signed [DATA_W-1:0] deriv_gain;
        logic [PERIOD_W-1:0]      sample_period;
        logic [ILIM_W-1:0]        integral_limit;
        logic signed [DATA_W-1:0] output_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        MA_ERR,
        MA_INTEG,
        MA_DIFF
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        MB_PERIOD,
        MB_PROP,
        MB_INTEG,
        MB_DERIV
    } mul_b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT
    } seq_cond_t;

    typedef struct packed {
        logic       mul_en;
        mul_a_sel_t mul_a;
        mul_b_sel_t mul_b;
        acc_op_t    acc_op;
        logic       integ_wr;
        logic       prev_wr;
        logic       err_wr;
        logic       out_wr;
    } ctrl_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

### design/pidc_regs.sv
// Configuration register file of the PID regulator, written over an APB-style port.
// Depends on pidc_pkg for the register map, reset values and cfg_t.
`default_nettype none

module pidc_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [pidc_pkg::APB_AW-1:0]  paddr,
    input  wire logic [pidc_pkg::APB_DW-1:0]  pwdata,
    output logic      [pidc_pkg::APB_DW-1:0]  prdata,
    output logic                              pready,
    output pidc_pkg::cfg_t                    cfg
);
    import pidc_pkg::*;

    cfg_t                cfg_reg;
    logic [REG_IX_W-1:0] reg_ix;
    logic                wr_en;

    assign reg_ix = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain      <= RST_PROP_GAIN;
            cfg_reg.integ_gain     <= RST_INTEG_GAIN;
            cfg_reg.deriv_gain     <= RST_DERIV_GAIN;
            cfg_reg.sample_period  <= RST_PERIOD;
            cfg_reg.integral_limit <= RST_INTEG_LIM;
            cfg_reg.output_limit   <= RST_OUT_LIM;
        end else if (wr_en) begin
            unique case (reg_ix)
                REG_PROP_GAIN:  cfg_reg.prop_gain      <= DATA_W'(pwdata);
                REG_INTEG_GAIN: cfg_reg.integ_gain     <= DATA_W'(pwdata);
                REG_DERIV_GAIN: cfg_reg.deriv_gain     <= DATA_W'(pwdata);
                REG_PERIOD:     cfg_reg.sample_period  <= pwdata[PERIOD_W-1:0];
                REG_INTEG_LIM:  cfg_reg.integral_limit <= pwdata[ILIM_W-1:0];
                REG_OUT_LIM:    cfg_reg.output_limit   <= DATA_W'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_ix)
            REG_PROP_GAIN:  prdata = APB_DW'(cfg_reg.prop_gain);
            REG_INTEG_GAIN: prdata = APB_DW'(cfg_reg.integ_gain);
            REG_DERIV_GAIN: prdata = APB_DW'(cfg_reg.deriv_gain);
            REG_PERIOD:     prdata = APB_DW'(cfg_reg.sample_period);
            REG_INTEG_LIM:  prdata = APB_DW'(cfg_reg.integral_limit);
            REG_OUT_LIM:    prdata = APB_DW'(cfg_reg.output_limit);
            default:        prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

### design/pidc_seq.sv
// Microcode sequencer of the PID regulator: step counter, control store and jump logic.
// Depends on pidc_pkg for ctrl_t, stat_t and the microcode field codes.
`default_nettype none

module pidc_seq (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire pidc_pkg::stat_t stat,
    output pidc_pkg::ctrl_t      ctrl
);
    import pidc_pkg::*;

    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;

    typedef struct packed {
        seq_cond_t cond;
        ctrl_t     ctl;
    } ucode_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{cond: SEQ_NEXT,
              ctl: '{mul_en: 1'b0, mul_a: MA_ERR, mul_b: MB_PERIOD, acc_op: ACC_HOLD,
                     integ_wr: 1'b0, prev_wr: 1'b0, err_wr: 1'b0, out_wr: 1'b0}};
        case (pc)
            3'd0: begin
                w.cond       = SEQ_WAIT_IN;
                w.ctl.err_wr = 1'b1;
            end
            3'd1: begin
                w.ctl.mul_en = 1'b1;
                w.ctl.mul_a  = MA_ERR;
                w.ctl.mul_b  = MB_PERIOD;
            end
            3'd2: begin
                w.ctl.integ_wr = 1'b1;
                w.ctl.mul_en   = 1'b1;
                w.ctl.mul_a    = MA_ERR;
                w.ctl.mul_b    = MB_PROP;
            end
            3'd3: begin
                w.ctl.acc_op = ACC_LOAD;
                w.ctl.mul_en = 1'b1;
                w.ctl.mul_a  = MA_INTEG;
                w.ctl.mul_b  = MB_INTEG;
            end
            3'd4: begin
                w.ctl.acc_op  = ACC_ADD;
                w.ctl.mul_en  = 1'b1;
                w.ctl.mul_a   = MA_DIFF;
                w.ctl.mul_b   = MB_DERIV;
                w.ctl.prev_wr = 1'b1;
            end
            3'd5: begin
                w.ctl.acc_op = ACC_ADD;
            end
            3'd6: begin
                w.cond       = SEQ_WAIT_OUT;
                w.ctl.out_wr = 1'b1;
            end
            default: begin
                w.cond = SEQ_WAIT_OUT;
            end
        endcase
        return w;
    endfunction

    logic [PC_W-1:0] pc_reg, pc_next;
    ucode_t          word;
    logic            in_accept;

    assign word      = ucode_rom(pc_reg);
    assign s_tready  = (word.cond == SEQ_WAIT_IN);
    assign in_accept = s_tready && s_tvalid;

    always_comb begin
        ctrl        = word.ctl;
        ctrl.err_wr = word.ctl.err_wr && in_accept;
        ctrl.out_wr = word.ctl.out_wr && stat.out_free;
        unique case (word.cond)
            SEQ_NEXT:     pc_next = PC_W'(pc_reg + 1'b1);
            SEQ_WAIT_IN:  pc_next = in_accept ? PC_W'(pc_reg + 1'b1) : pc_reg;
            SEQ_WAIT_OUT: pc_next = stat.out_free ? STEP_IDLE : pc_reg;
            default:      pc_next = STEP_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

### design/pidc_datapath.sv
// Datapath of the PID regulator: error, integral and previous-error registers, one shared
// multiplier, the accumulator, the output limiter and the result register.
// Depends on pidc_pkg and is driven by the control word from pidc_seq.
`default_nettype none

module pidc_datapath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [pidc_pkg::S_TDATA_W-1:0]  s_tdata,
    input  wire pidc_pkg::cfg_t                  cfg,
    input  wire pidc_pkg::ctrl_t                 ctrl,
    output pidc_pkg::stat_t                      stat,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [pidc_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic      [pidc_pkg::M_TUSER_W-1:0]  m_tuser
);
    import pidc_pkg::*;

    logic signed [DATA_W-1:0] target, measured;
    logic signed [OP_W-1:0]   in_diff;
    logic signed [DATA_W-1:0] err_sat;

    logic signed [DATA_W-1:0] err_reg, integral_reg, integral_next, prev_reg;
    logic signed [OP_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SHP_W-1:0]  prod_sh;
    logic signed [ACC_W-1:0]  acc_reg;

    logic signed [ACC_W-1:0]  integ_sum, ilim_pos, ilim_neg;
    logic signed [ACC_W-1:0]  olim, dmax, dmin;
    logic signed [DATA_W-1:0] drive_next;
    logic                     lim_next;

    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     lim_reg;

    assign target   = s_tdata[DATA_W-1:0];
    assign measured = s_tdata[2*DATA_W-1:DATA_W];
    assign in_diff  = OP_W'(target) - OP_W'(measured);

    always_comb begin
        if (in_diff[OP_W-1] != in_diff[OP_W-2]) begin
            err_sat = in_diff[OP_W-1] ? DATA_MIN : DATA_MAX;
        end else begin
            err_sat = DATA_W'(in_diff);
        end
    end

    always_comb begin
        unique case (ctrl.mul_a)
            MA_ERR:   mul_a = OP_W'(err_reg);
            MA_INTEG: mul_a = OP_W'(integral_reg);
            MA_DIFF:  mul_a = OP_W'(err_reg) - OP_W'(prev_reg);
            default:  mul_a = '0;
        endcase
        unique case (ctrl.mul_b)
            MB_PERIOD: mul_b = $signed({{(OP_W-PERIOD_W){1'b0}}, cfg.sample_period});
            MB_PROP:   mul_b = OP_W'(cfg.prop_gain);
            MB_INTEG:  mul_b = OP_W'(cfg.integ_gain);
            MB_DERIV:  mul_b = OP_W'(cfg.deriv_gain);
            default:   mul_b = '0;
        endcase
    end

    assign prod_sh = prod_reg[PROD_W-1:FRAC_W];

    always_comb begin
        integ_sum = ACC_W'(integral_reg) + ACC_W'(prod_sh);
        ilim_pos  = $signed({{(ACC_W-ILIM_W){1'b0}}, cfg.integral_limit});
        ilim_neg  = -ilim_pos;
        if (integ_sum > ilim_pos) begin
            integral_next = DATA_W'(ilim_pos);
        end else if (integ_sum < ilim_neg) begin
            integral_next = DATA_W'(ilim_neg);
        end else begin
            integral_next = DATA_W'(integ_sum);
        end
    end

    always_comb begin
        olim       = ACC_W'(cfg.output_limit);
        dmax       = ACC_W'(DATA_MAX);
        dmin       = ACC_W'(DATA_MIN);
        drive_next = DATA_W'(acc_reg);
        lim_next   = 1'b0;
        if (acc_reg > olim) begin
            drive_next = cfg.output_limit;
            lim_next   = 1'b1;
        end else if (acc_reg > dmax) begin
            drive_next = DATA_MAX;
            lim_next   = 1'b1;
        end else if (acc_reg < dmin) begin
            drive_next = DATA_MIN;
            lim_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integral_reg <= '0;
            prev_reg     <= '0;
        end else begin
            if (ctrl.integ_wr) begin
                integral_reg <= integral_next;
            end
            if (ctrl.prev_wr) begin
                prev_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.err_wr) begin
            err_reg <= err_sat;
        end
        if (ctrl.mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
        case (ctrl.acc_op)
            ACC_LOAD: acc_reg <= ACC_W'(prod_sh);
            ACC_ADD:  acc_reg <= acc_reg + ACC_W'(prod_sh);
            default:  acc_reg <= acc_reg;
        endcase
        if (ctrl.out_wr) begin
            drive_reg <= drive_next;
            lim_reg   <= lim_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctrl.out_wr) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = M_TDATA_W'(drive_reg);
    assign m_tuser       = M_TUSER_W'(lim_reg);

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.out_wr |-> (!out_valid_reg || m_tready))
        else $error("result register loaded while a result was still waiting");

    a_unlimited_below: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !lim_reg) |-> (drive_reg <= cfg.output_limit))
        else $error("unflagged drive above the output limit");

    a_limited_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && lim_reg) |-> (drive_reg == cfg.output_limit || drive_reg == DATA_MIN))
        else $error("flagged drive is neither the output limit nor the negative bound");

    a_acc_after_integ: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.acc_op == ACC_LOAD) |-> $past(ctrl.integ_wr))
        else $error("drive accumulation started before the integral update");

endmodule

`default_nettype wire

### design/pid_regulator_integral_clamp.sv
// Top level of the PID regulator with integral clamp.
// Instantiates pidc_regs, pidc_seq and pidc_datapath; depends on pidc_pkg.
//
// Each request on the input stream is one control tick carrying target and measured values
// in signed Q16.16; it yields exactly one result carrying the drive and a limit flag. The
// block works on one tick at a time: a request is taken in the sequencer's wait step and its
// result is loaded into the output register in the last microcode step, once the output
// register is free; only then does the block take a new request. The microcode program runs
// the one shared 33 by 33 bit multiplier four times per tick (integral step, then the
// proportional, integral and derivative terms). While a result waits in the output register
// the next tick is already accepted and computed. Configuration registers sit at byte
// addresses 4*i and are to be written only while the block is idle.
`default_nettype none

module pid_regulator_integral_clamp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata fields from bit 0 up: target[31:0], measured[63:32].
    input  wire logic [pidc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata fields from bit 0 up: drive[31:0].
    output logic      [pidc_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser fields from bit 0 up: limited[0].
    output logic      [pidc_pkg::M_TUSER_W-1:0]  m_tuser,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [pidc_pkg::APB_AW-1:0]     paddr,
    input  wire logic [pidc_pkg::APB_DW-1:0]     pwdata,
    output logic      [pidc_pkg::APB_DW-1:0]     prdata,
    output logic                                 pready
);
    import pidc_pkg::*;

    cfg_t  cfg;
    ctrl_t ctrl;
    stat_t stat;

    pidc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidc_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    pidc_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .ctrl     (ctrl),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
